// ----- rtl/lpu8_pkg.sv -----
package lpu8_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_OVERSIZED = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    localparam logic [31:0] MAX_LENGTH_RESET = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_STRING  = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    // Constraint on the next continuation byte
    typedef enum logic [2:0] {
        LC_NONE     = 3'd0,
        LC_ANY      = 3'd1,
        LC_MIN_A0   = 3'd2,
        LC_BELOW_A0 = 3'd3,
        LC_MIN_90   = 3'd4,
        LC_MAX_8F   = 3'd5
    } lead_class_t;

    typedef enum logic [3:0] {
        BC_ASCII    = 4'd0,
        BC_CONT_LO  = 4'd1,  // 0x80..0x8F
        BC_CONT_MID = 4'd2,  // 0x90..0x9F
        BC_CONT_HI  = 4'd3,  // 0xA0..0xBF
        BC_LEAD2    = 4'd4,
        BC_LEAD3_E0 = 4'd5,
        BC_LEAD3_ED = 4'd6,
        BC_LEAD3    = 4'd7,
        BC_LEAD4_F0 = 4'd8,
        BC_LEAD4_F4 = 4'd9,
        BC_LEAD4    = 4'd10,
        BC_INVALID  = 4'd11
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        buffer_last;
        byte_class_t byte_class;
    } front_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] string_length;
    } result_t;

    typedef struct packed {
        logic take;
        logic res_push;
    } back_status_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        if (b <= 8'h7F)
            c = BC_ASCII;
        else if ((b & 8'hC0) == 8'h80)
            c = (b < 8'h90) ? BC_CONT_LO : (b < 8'hA0) ? BC_CONT_MID : BC_CONT_HI;
        else if (b >= 8'hC2 && b <= 8'hDF)
            c = BC_LEAD2;
        else if (b == 8'hE0)
            c = BC_LEAD3_E0;
        else if (b == 8'hED)
            c = BC_LEAD3_ED;
        else if (b >= 8'hE0 && b <= 8'hEF)
            c = BC_LEAD3;
        else if (b == 8'hF0)
            c = BC_LEAD4_F0;
        else if (b == 8'hF4)
            c = BC_LEAD4_F4;
        else if (b >= 8'hF0 && b <= 8'hF4)
            c = BC_LEAD4;
        else
            c = BC_INVALID;
        return c;
    endfunction

endpackage

// ----- rtl/lpu8_front.sv -----
module lpu8_front
    import lpu8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        buffer_last,
    output logic        item_valid,
    output front_item_t item,
    input  logic        take
);

    front_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                wr_en;
    logic                rd_en;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = entry_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = take && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Classify on the way in so the back end only sees byte classes
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= '{data_byte:   data_byte,
                                       buffer_last: buffer_last,
                                       byte_class:  classify(data_byte)};
        end
    end

endmodule

// ----- rtl/lpu8_back.sv -----
module lpu8_back
    import lpu8_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         max_length_we,
    input  logic [31:0]  max_length_wdata,
    input  logic         item_valid,
    input  front_item_t  item,
    output back_status_t back_status,
    output logic         empty,
    input  logic         pop,
    output logic [1:0]   status,
    output logic [31:0]  string_length
);

    logic [31:0]       max_length_reg;
    phase_t            phase_reg, phase_next;
    logic [1:0]        prefix_count_reg, prefix_count_next;
    logic [31:0]       length_accum_reg, length_accum_next;
    logic [31:0]       bytes_left_reg, bytes_left_next;
    logic [1:0]        cont_needed_reg, cont_needed_next;
    lead_class_t       lead_class_reg, lead_class_next;
    logic              utf8_bad_reg, utf8_bad_next;

    logic [1:0]        chk_cont;
    lead_class_t       chk_lead;
    logic              chk_bad;
    logic              cont_ok;
    logic [31:0]       accum_new;
    logic              string_done;
    logic              string_bad;

    logic              take;
    logic              res_push;
    result_t           res_data;

    result_t           res_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] res_count_reg, res_count_next;
    logic              rd_en;

    assign take        = item_valid && (res_count_reg != QCNT_W'(QUEUE_DEPTH));
    assign back_status = '{take: take, res_push: res_push};

    assign accum_new   = length_accum_reg
                         | ({24'd0, item.data_byte} << {prefix_count_reg, 3'b000});
    assign string_done = (bytes_left_reg == 32'd1);
    assign string_bad  = chk_bad || (chk_cont != 2'd0);

    // Continuation byte against the constraint left by its lead byte
    always_comb
    begin
        case (lead_class_reg)
            LC_MIN_A0:   cont_ok = (item.byte_class == BC_CONT_HI);
            LC_BELOW_A0: cont_ok = (item.byte_class == BC_CONT_LO)
                                   || (item.byte_class == BC_CONT_MID);
            LC_MIN_90:   cont_ok = (item.byte_class == BC_CONT_MID)
                                   || (item.byte_class == BC_CONT_HI);
            LC_MAX_8F:   cont_ok = (item.byte_class == BC_CONT_LO);
            default:     cont_ok = (item.byte_class == BC_CONT_LO)
                                   || (item.byte_class == BC_CONT_MID)
                                   || (item.byte_class == BC_CONT_HI);
        endcase
    end

    always_comb
    begin
        chk_cont = cont_needed_reg;
        chk_lead = lead_class_reg;
        chk_bad  = utf8_bad_reg;
        if (!utf8_bad_reg)
        begin
            if (cont_needed_reg != 2'd0)
            begin
                if (!cont_ok)
                begin
                    chk_bad = 1'b1;
                end
                else
                begin
                    chk_cont = cont_needed_reg - 2'd1;
                    chk_lead = (cont_needed_reg == 2'd1) ? LC_NONE : LC_ANY;
                end
            end
            else
            begin
                case (item.byte_class)
                    BC_ASCII:    ;
                    BC_LEAD2:    begin chk_cont = 2'd1; chk_lead = LC_ANY;      end
                    BC_LEAD3_E0: begin chk_cont = 2'd2; chk_lead = LC_MIN_A0;   end
                    BC_LEAD3_ED: begin chk_cont = 2'd2; chk_lead = LC_BELOW_A0; end
                    BC_LEAD3:    begin chk_cont = 2'd2; chk_lead = LC_ANY;      end
                    BC_LEAD4_F0: begin chk_cont = 2'd3; chk_lead = LC_MIN_90;   end
                    BC_LEAD4_F4: begin chk_cont = 2'd3; chk_lead = LC_MAX_8F;   end
                    BC_LEAD4:    begin chk_cont = 2'd3; chk_lead = LC_ANY;      end
                    default:     chk_bad = 1'b1;
                endcase
            end
        end
    end

    // Next state
    always_comb
    begin
        phase_next        = phase_reg;
        prefix_count_next = prefix_count_reg;
        length_accum_next = length_accum_reg;
        bytes_left_next   = bytes_left_reg;
        cont_needed_next  = cont_needed_reg;
        lead_class_next   = lead_class_reg;
        utf8_bad_next     = utf8_bad_reg;
        if (take)
        begin
            case (phase_reg)
                PH_DISCARD:
                begin
                    if (item.buffer_last)
                    begin
                        phase_next        = PH_PREFIX;
                        prefix_count_next = 2'd0;
                        length_accum_next = '0;
                        bytes_left_next   = '0;
                        cont_needed_next  = 2'd0;
                        lead_class_next   = LC_NONE;
                        utf8_bad_next     = 1'b0;
                    end
                end
                PH_STRING:
                begin
                    if (string_done || item.buffer_last)
                    begin
                        phase_next        = (string_done && string_bad && !item.buffer_last)
                                            ? PH_DISCARD : PH_PREFIX;
                        prefix_count_next = 2'd0;
                        length_accum_next = '0;
                        bytes_left_next   = '0;
                        cont_needed_next  = 2'd0;
                        lead_class_next   = LC_NONE;
                        utf8_bad_next     = 1'b0;
                    end
                    else
                    begin
                        bytes_left_next  = bytes_left_reg - 32'd1;
                        cont_needed_next = chk_cont;
                        lead_class_next  = chk_lead;
                        utf8_bad_next    = chk_bad;
                    end
                end
                default:
                begin
                    phase_next        = PH_PREFIX;
                    prefix_count_next = prefix_count_reg + 2'd1;
                    length_accum_next = accum_new;
                    if (item.buffer_last || (prefix_count_reg == 2'd3 &&
                        (accum_new > max_length_reg || accum_new == 32'd0)))
                    begin
                        if (prefix_count_reg == 2'd3 && accum_new > max_length_reg
                            && !item.buffer_last)
                        begin
                            phase_next = PH_DISCARD;
                        end
                        prefix_count_next = 2'd0;
                        length_accum_next = '0;
                        bytes_left_next   = '0;
                        cont_needed_next  = 2'd0;
                        lead_class_next   = LC_NONE;
                        utf8_bad_next     = 1'b0;
                    end
                    else if (prefix_count_reg == 2'd3)
                    begin
                        phase_next       = PH_STRING;
                        bytes_left_next  = accum_new;
                        cont_needed_next = 2'd0;
                        lead_class_next  = LC_NONE;
                        utf8_bad_next    = 1'b0;
                    end
                end
            endcase
        end
    end

    // Result generation
    always_comb
    begin
        res_push = 1'b0;
        res_data = '{status: ST_OK, string_length: '0};
        if (take)
        begin
            case (phase_reg)
                PH_DISCARD: ;
                PH_STRING:
                begin
                    if (string_done)
                    begin
                        res_push = 1'b1;
                        res_data = '{status: string_bad ? ST_INVALID : ST_OK,
                                     string_length: length_accum_reg};
                    end
                    else if (item.buffer_last)
                    begin
                        res_push = 1'b1;
                        res_data = '{status: ST_MALFORMED, string_length: length_accum_reg};
                    end
                end
                default:
                begin
                    if (prefix_count_reg != 2'd3)
                    begin
                        if (item.buffer_last)
                        begin
                            res_push = 1'b1;
                            res_data = '{status: ST_MALFORMED, string_length: '0};
                        end
                    end
                    else if (accum_new > max_length_reg)
                    begin
                        res_push = 1'b1;
                        res_data = '{status: ST_OVERSIZED, string_length: accum_new};
                    end
                    else if (accum_new == 32'd0)
                    begin
                        res_push = 1'b1;
                        res_data = '{status: ST_OK, string_length: '0};
                    end
                    else if (item.buffer_last)
                    begin
                        res_push = 1'b1;
                        res_data = '{status: ST_MALFORMED, string_length: accum_new};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg   <= MAX_LENGTH_RESET;
            phase_reg        <= PH_PREFIX;
            prefix_count_reg <= 2'd0;
            length_accum_reg <= '0;
            bytes_left_reg   <= '0;
            cont_needed_reg  <= 2'd0;
            lead_class_reg   <= LC_NONE;
            utf8_bad_reg     <= 1'b0;
        end
        else
        begin
            if (max_length_we)
            begin
                max_length_reg <= max_length_wdata;
            end
            phase_reg        <= phase_next;
            prefix_count_reg <= prefix_count_next;
            length_accum_reg <= length_accum_next;
            bytes_left_reg   <= bytes_left_next;
            cont_needed_reg  <= cont_needed_next;
            lead_class_reg   <= lead_class_next;
            utf8_bad_reg     <= utf8_bad_next;
        end
    end

    // Result queue: holds finished transactions while the consumer stalls
    assign empty         = (res_count_reg == '0);
    assign status        = res_reg[rd_ptr_reg].status;
    assign string_length = res_reg[rd_ptr_reg].string_length;
    assign rd_en         = pop && !empty;

    always_comb
    begin
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        res_count_next = res_count_reg;
        if (res_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (res_push && !rd_en)
        begin
            res_count_next = res_count_reg + 1'b1;
        end
        else if (rd_en && !res_push)
        begin
            res_count_next = res_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg[wr_ptr_reg] <= res_data;
        end
    end

endmodule

// ----- rtl/length_prefixed_utf8_checker.sv -----
// Results: a status enters the result queue on the clock edge that accepts the byte ending
// its string (or the buffer); bytes that close nothing give no status.
// Throughput: one byte per cycle while the result queue is not full; a two-entry queue
// on each side decouples input and result stalls.
// Reset (rst_n, asynchronous): empties both queues, expects a new length prefix and
// sets max_length to all ones.
module length_prefixed_utf8_checker
    import lpu8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        max_length_we,
    input  logic [31:0] max_length_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        buffer_last,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [31:0] string_length
);

    logic         item_valid;
    front_item_t  item;
    back_status_t back_status;

    lpu8_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .buffer_last (buffer_last),
        .item_valid  (item_valid),
        .item        (item),
        .take        (back_status.take)
    );

    lpu8_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .max_length_we    (max_length_we),
        .max_length_wdata (max_length_wdata),
        .item_valid       (item_valid),
        .item             (item),
        .back_status      (back_status),
        .empty            (empty),
        .pop              (pop),
        .status           (status),
        .string_length    (string_length)
    );

`ifndef SYNTHESIS
    a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.take |-> item_valid)
        else $error("back end took a transaction from an empty front queue");

    a_push_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.res_push |-> back_status.take)
        else $error("result produced without a byte being consumed");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !back_status.take) |=> item_valid)
        else $error("front queue lost an item while the back end stalled");

    a_oversized_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_OVERSIZED) |-> (string_length != 32'd0))
        else $error("oversized status with zero length");
`endif

endmodule
